// ===== rtl/ofsi_pkg.sv =====
`timescale 1ns / 1ps

package ofsi_pkg;

	localparam int VAL_W     = 48;
	localparam int FRAC_BITS = 24;
	localparam int MAX_STEPS = 1024;
	localparam int N_W       = 11;
	localparam int MUL_W     = 64;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int KS_W      = 51;
	localparam int DIV_W     = 50;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int Y4HI_W    = MUL_W - FRAC_BITS;

	// Reciprocal of six, (2^53 + 4) / 6, exact for dividends below 2^50.
	localparam int               DIV6_SH = 53;
	localparam logic [MUL_W-1:0] RECIP6  = 64'h0005_5555_5555_5556;

	localparam logic [VAL_W-1:0] VAL_MAX     = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_MIN     = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [MUL_W-1:0] COEFF_RESET = 64'd18446744;

	localparam logic [1:0] METH_EULER = 2'd0;
	localparam logic [1:0] METH_HEUN  = 2'd1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_HSET,
		OP_Y2,
		OP_Y4,
		OP_KHI,
		OP_SLOPE,
		OP_ACC,
		OP_MBSUM,
		OP_MBQ,
		OP_HK,
		OP_PUB
	} dp_op_t;

	typedef enum logic [2:0] {
		MS_Y2,
		MS_Y4,
		MS_KHI,
		MS_KLO,
		MS_HK,
		MS_DIV6
	} mul_sel_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DIV_H,
		S_HSET,
		S_Y2_MUL,
		S_Y2_FIN,
		S_Y4_MUL,
		S_Y4_FIN,
		S_KHI_MUL,
		S_KHI_FIN,
		S_KLO_MUL,
		S_KLO_FIN,
		S_ACC,
		S_MBSUM,
		S_DIV6,
		S_MBQ,
		S_HK_MUL,
		S_HK_FIN,
		S_PUB
	} state_t;

	typedef struct packed {
		dp_op_t   op;
		mul_sel_t mul_sel;
		logic     mul_go;
		logic     div_go;
		logic     half;
		logic     to_y;
		logic     acc_clr;
		logic     acc_dbl;
	} cmd_t;

	typedef struct packed {
		logic [1:0]     method;
		logic [N_W-1:0] n_steps;
		logic           mul_done;
		logic           div_done;
	} stat_t;

endpackage

// ===== rtl/ode_fixed_step_integrator.sv =====
`timescale 1ns / 1ps

// Channel  Handshake               Payload
// in       in_valid / in_ready     action, x_end, x_start, y_start, step_count
// out      out_valid / out_ready   y_end, saturated
// cfg      cfg_wr_en               cfg_wr_data (decay coefficient)
//
// One request at a time. Setup divides the step width, then each step (Euler, Heun or
// RK4) runs its products one after another on the shared 64x64 multiplier; RK4 also
// divides its slope sum by six through a reciprocal product on the same multiplier.
// The finished result sits in an output register, so a new request is taken
// while it waits. Reset clears the control state and loads the coefficient.

module ode_fixed_step_integrator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        action,
	input  logic signed [ofsi_pkg::VAL_W-1:0] x_end,
	input  logic signed [ofsi_pkg::VAL_W-1:0] x_start,
	input  logic signed [ofsi_pkg::VAL_W-1:0] y_start,
	input  logic [ofsi_pkg::N_W-1:0]          step_count,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ofsi_pkg::VAL_W-1:0] y_end,
	output logic                              saturated,
	input  logic                              cfg_wr_en,
	input  logic [ofsi_pkg::MUL_W-1:0]        cfg_wr_data
);
	import ofsi_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	ofsi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ofsi_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.action      (action),
		.x_end       (x_end),
		.x_start     (x_start),
		.y_start     (y_start),
		.step_count  (step_count),
		.y_end       (y_end),
		.saturated   (saturated)
	);

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("block took a second request while busy");

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mul_go && cmd.div_go))
		else $error("multiplier and divider driven at once");

	a_mul_done_go: assert property (@(posedge clk) disable iff (!arst_n)
		stat.mul_done |-> cmd.mul_go && !in_ready)
		else $error("multiplier finished outside a multiply");
`endif

endmodule

// ===== rtl/ofsi_mul.sv =====
`timescale 1ns / 1ps

module ofsi_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [ofsi_pkg::MUL_W-1:0] a,
	input  logic [ofsi_pkg::MUL_W-1:0] b,
	output logic                       done,
	output logic [ofsi_pkg::PROD_W-1:0] prod
);
	import ofsi_pkg::*;

	localparam int HW = MUL_W / 2;

	logic [2:0]        cnt_q;
	logic [MUL_W-1:0]  pp_s1;
	logic [1:0]        pos_s1;
	logic [PROD_W-1:0] acc_q;
	logic [HW-1:0]     a_half, b_half;
	logic [PROD_W-1:0] pp_shifted;

	// One 32x32 partial product per cycle while go is held, registered and added in the next cycle.
	assign a_half = cnt_q[1] ? a[MUL_W-1:HW] : a[HW-1:0];
	assign b_half = cnt_q[0] ? b[MUL_W-1:HW] : b[HW-1:0];

	always_comb begin
		unique case (pos_s1)
			2'd0:    pp_shifted = {{MUL_W{1'b0}}, pp_s1};
			2'd1:    pp_shifted = {{HW{1'b0}}, pp_s1, {HW{1'b0}}};
			default: pp_shifted = {pp_s1, {MUL_W{1'b0}}};
		endcase
	end

	assign done = go && (cnt_q == 3'd4);
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (!go || cnt_q == 3'd4) begin
			cnt_q <= 3'd0;
		end else begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (cnt_q == 3'd0) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_q + pp_shifted;
			end
			if (cnt_q != 3'd4) begin
				pp_s1  <= a_half * b_half;
				pos_s1 <= 2'({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]});
			end
		end
	end

endmodule

// ===== rtl/ofsi_div.sv =====
`timescale 1ns / 1ps

module ofsi_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [ofsi_pkg::DIV_W-1:0] dividend,
	input  logic [ofsi_pkg::N_W-1:0]   divisor,
	output logic                       done,
	output logic [ofsi_pkg::DIV_W-1:0] quot
);
	import ofsi_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [N_W-1:0]       rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [N_W:0]         trial;
	logic [N_W:0]         diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};
	assign done  = go && (cnt_q == DIV_CNT_W'(DIV_W));
	assign quot  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (!go || cnt_q == DIV_CNT_W'(DIV_W)) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Restoring division, one quotient bit per cycle.
	always_ff @(posedge clk) begin
		if (go) begin
			if (cnt_q == '0) begin
				rem_q <= '0;
				quo_q <= dividend;
			end else begin
				rem_q <= ge ? diff[N_W-1:0] : trial[N_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], ge};
			end
		end
	end

endmodule

// ===== rtl/ofsi_dp.sv =====
`timescale 1ns / 1ps

module ofsi_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ofsi_pkg::cmd_t             cmd,
	output ofsi_pkg::stat_t            stat,
	input  logic                       cfg_wr_en,
	input  logic [ofsi_pkg::MUL_W-1:0] cfg_wr_data,
	input  logic [1:0]                 action,
	input  logic signed [ofsi_pkg::VAL_W-1:0] x_end,
	input  logic signed [ofsi_pkg::VAL_W-1:0] x_start,
	input  logic signed [ofsi_pkg::VAL_W-1:0] y_start,
	input  logic [ofsi_pkg::N_W-1:0]   step_count,
	output logic signed [ofsi_pkg::VAL_W-1:0] y_end,
	output logic                       saturated
);
	import ofsi_pkg::*;

	logic [MUL_W-1:0]  coeff_q;
	logic [1:0]        method_q;
	logic [N_W-1:0]    n_q;
	logic [VAL_W-1:0]  diffmag_q, h_q, y_q, yt_q, kcur_q, yout_q;
	logic [MUL_W-1:0]  y2_q, y4lo_q, tlo_q;
	logic [Y4HI_W-1:0] y4hi_q;
	logic              thi_nz_q, sat_q, satout_q;
	logic [KS_W-1:0]   ksum_q, mb_q;

	logic [VAL_W:0]    diff, diff_neg;
	logic [VAL_W-1:0]  diffmag, ymag;
	logic [N_W-1:0]    n_sel;
	logic [KS_W-1:0]   mbmag, ksmag, kadd, ksum_next, q_ext, mb_next;
	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] prod, hk_shift;
	logic              mul_done, div_done;
	logic [DIV_W-1:0]  div_num, quot;
	logic [N_W-1:0]    div_den;
	logic [MUL_W:0]    m_sum;
	logic              slope_bad, y2_bad, h_bad, hk_over, y_over, hk_neg;
	logic [VAL_W-1:0]  limit, mm, mq, y_new;
	logic [VAL_W:0]    y_sum;
	logic              sat_set;

	assign diff     = {x_end[VAL_W-1], x_end} - {x_start[VAL_W-1], x_start};
	assign diff_neg = (VAL_W+1)'(0) - diff;
	assign diffmag  = diff[VAL_W] ? diff_neg[VAL_W-1:0] : diff[VAL_W-1:0];

	always_comb begin
		if (step_count == '0) begin
			n_sel = N_W'(1);
		end else if (step_count > N_W'(MAX_STEPS)) begin
			n_sel = N_W'(MAX_STEPS);
		end else begin
			n_sel = step_count;
		end
	end

	assign ymag  = yt_q[VAL_W-1] ? (VAL_W'(0) - yt_q) : yt_q;
	assign mbmag = mb_q[KS_W-1] ? (KS_W'(0) - mb_q) : mb_q;
	assign ksmag = ksum_q[KS_W-1] ? (KS_W'(0) - ksum_q) : ksum_q;

	always_comb begin
		unique case (cmd.mul_sel)
			MS_Y2: begin
				mul_a = MUL_W'(ymag);
				mul_b = MUL_W'(ymag);
			end
			MS_Y4: begin
				mul_a = y2_q;
				mul_b = y2_q;
			end
			MS_KHI: begin
				mul_a = coeff_q;
				mul_b = MUL_W'(y4hi_q);
			end
			MS_KLO: begin
				mul_a = coeff_q;
				mul_b = y4lo_q;
			end
			MS_DIV6: begin
				mul_a = MUL_W'(ksmag);
				mul_b = RECIP6;
			end
			default: begin
				mul_a = MUL_W'(h_q);
				mul_b = MUL_W'(mbmag);
			end
		endcase
	end

	assign div_num = DIV_W'(diffmag_q);
	assign div_den = n_q;

	ofsi_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.mul_go),
		.a        (mul_a),
		.b        (mul_b),
		.done     (mul_done),
		.prod     (prod)
	);

	ofsi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quot     (quot)
	);

	assign stat.method   = method_q;
	assign stat.n_steps  = n_q;
	assign stat.mul_done = mul_done;
	assign stat.div_done = div_done;

	assign h_bad  = quot > DIV_W'(VAL_MAX);
	assign y2_bad = |prod[PROD_W-1:MUL_W+FRAC_BITS];

	// Slope magnitude: low word of k*y4hi plus high word of k*y4lo.
	assign m_sum     = {1'b0, tlo_q} + {1'b0, prod[PROD_W-1:MUL_W]};
	assign slope_bad = thi_nz_q || m_sum[MUL_W] || (m_sum[MUL_W-1:0] > MUL_W'(VAL_MAX));

	assign kadd = cmd.acc_dbl ? {{2{kcur_q[VAL_W-1]}}, kcur_q, 1'b0}
	                          : {{3{kcur_q[VAL_W-1]}}, kcur_q};
	assign ksum_next = (cmd.acc_clr ? KS_W'(0) : ksum_q) + kadd;
	assign q_ext     = KS_W'(prod >> DIV6_SH);
	assign mb_next   = ksum_q[KS_W-1] ? (KS_W'(0) - q_ext) : q_ext;

	// h * slope: truncate the magnitude, clamp, then apply the sign.
	assign hk_shift = cmd.half ? (prod >> (FRAC_BITS + 1)) : (prod >> FRAC_BITS);
	assign hk_neg   = mb_q[KS_W-1];
	assign limit    = hk_neg ? VAL_MIN : VAL_MAX;
	assign hk_over  = (|hk_shift[PROD_W-1:VAL_W]) || (hk_shift[VAL_W-1:0] > limit);
	assign mm       = hk_over ? limit : hk_shift[VAL_W-1:0];
	assign mq       = hk_neg ? (VAL_W'(0) - mm) : mm;
	assign y_sum    = {y_q[VAL_W-1], y_q} + {mq[VAL_W-1], mq};
	assign y_over   = y_sum[VAL_W] != y_sum[VAL_W-1];
	assign y_new    = y_over ? (y_sum[VAL_W] ? VAL_MIN : VAL_MAX) : y_sum[VAL_W-1:0];

	always_comb begin
		unique case (cmd.op)
			OP_HSET:  sat_set = h_bad;
			OP_Y2:    sat_set = y2_bad;
			OP_SLOPE: sat_set = slope_bad;
			OP_HK:    sat_set = hk_over || y_over;
			default:  sat_set = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= COEFF_RESET;
		end else if (cfg_wr_en) begin
			coeff_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		sat_q <= (cmd.op == OP_LOAD) ? 1'b0 : (sat_q || sat_set);
		unique case (cmd.op)
			OP_LOAD: begin
				method_q  <= action;
				n_q       <= n_sel;
				diffmag_q <= diffmag;
				y_q       <= y_start;
				yt_q      <= y_start;
			end
			OP_HSET: begin
				h_q <= h_bad ? VAL_MAX : quot[VAL_W-1:0];
			end
			OP_Y2: begin
				y2_q <= y2_bad ? {MUL_W{1'b1}} : prod[MUL_W+FRAC_BITS-1:FRAC_BITS];
			end
			OP_Y4: begin
				y4hi_q <= prod[PROD_W-1:MUL_W+FRAC_BITS];
				y4lo_q <= prod[MUL_W+FRAC_BITS-1:FRAC_BITS];
			end
			OP_KHI: begin
				thi_nz_q <= |prod[PROD_W-1:MUL_W];
				tlo_q    <= prod[MUL_W-1:0];
			end
			OP_SLOPE: begin
				kcur_q <= VAL_W'(0) - (slope_bad ? VAL_MAX : m_sum[VAL_W-1:0]);
			end
			OP_ACC: begin
				ksum_q <= ksum_next;
				mb_q   <= {{(KS_W-VAL_W){kcur_q[VAL_W-1]}}, kcur_q};
			end
			OP_MBSUM: begin
				mb_q <= ksum_q;
			end
			OP_MBQ: begin
				mb_q <= mb_next;
			end
			OP_HK: begin
				yt_q <= y_new;
				if (cmd.to_y) begin
					y_q <= y_new;
				end
			end
			OP_PUB: begin
				yout_q   <= y_q;
				satout_q <= sat_q;
			end
			default: begin
			end
		endcase
	end

	assign y_end     = yout_q;
	assign saturated = satout_q;

endmodule

// ===== rtl/ofsi_ctrl.sv =====
`timescale 1ns / 1ps

module ofsi_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  ofsi_pkg::stat_t stat,
	output ofsi_pkg::cmd_t  cmd
);
	import ofsi_pkg::*;

	state_t         state_q, state_d;
	logic [1:0]     stage_q, stage_d;
	logic [N_W-1:0] step_q, step_d;
	logic           ovalid_q;
	logic           is_euler, is_heun, is_rk4, last_stage, last_step;

	assign is_euler = stat.method == METH_EULER;
	assign is_heun  = stat.method == METH_HEUN;
	assign is_rk4   = !is_euler && !is_heun;

	// The stage that closes a step writes y as well as the trial value.
	assign last_stage = is_euler || (is_heun && stage_q == 2'd1) || (is_rk4 && stage_q == 2'd3);
	assign last_step  = step_q == (stat.n_steps - N_W'(1));

	always_comb begin
		state_d     = state_q;
		stage_d     = stage_q;
		step_d      = step_q;
		cmd         = '0;
		cmd.op      = OP_NONE;
		cmd.mul_sel = MS_Y2;
		in_ready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					stage_d = 2'd0;
					step_d  = '0;
					state_d = S_DIV_H;
				end
			end
			S_DIV_H: begin
				cmd.div_go = 1'b1;
				if (stat.div_done) begin
					state_d = S_HSET;
				end
			end
			S_HSET: begin
				cmd.op  = OP_HSET;
				state_d = S_Y2_MUL;
			end
			S_Y2_MUL: begin
				cmd.mul_go = 1'b1;
				if (stat.mul_done) begin
					state_d = S_Y2_FIN;
				end
			end
			S_Y2_FIN: begin
				cmd.op  = OP_Y2;
				state_d = S_Y4_MUL;
			end
			S_Y4_MUL: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MS_Y4;
				if (stat.mul_done) begin
					state_d = S_Y4_FIN;
				end
			end
			S_Y4_FIN: begin
				cmd.op  = OP_Y4;
				state_d = S_KHI_MUL;
			end
			S_KHI_MUL: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MS_KHI;
				if (stat.mul_done) begin
					state_d = S_KHI_FIN;
				end
			end
			S_KHI_FIN: begin
				cmd.op  = OP_KHI;
				state_d = S_KLO_MUL;
			end
			S_KLO_MUL: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MS_KLO;
				if (stat.mul_done) begin
					state_d = S_KLO_FIN;
				end
			end
			S_KLO_FIN: begin
				cmd.op  = OP_SLOPE;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.op      = OP_ACC;
				cmd.acc_clr = stage_q == 2'd0;
				cmd.acc_dbl = is_rk4 && (stage_q == 2'd1 || stage_q == 2'd2);
				if (last_stage && is_heun) begin
					state_d = S_MBSUM;
				end else if (last_stage && is_rk4) begin
					state_d = S_DIV6;
				end else begin
					state_d = S_HK_MUL;
				end
			end
			S_MBSUM: begin
				cmd.op  = OP_MBSUM;
				state_d = S_HK_MUL;
			end
			S_DIV6: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MS_DIV6;
				if (stat.mul_done) begin
					state_d = S_MBQ;
				end
			end
			S_MBQ: begin
				cmd.op  = OP_MBQ;
				state_d = S_HK_MUL;
			end
			S_HK_MUL: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MS_HK;
				if (stat.mul_done) begin
					state_d = S_HK_FIN;
				end
			end
			S_HK_FIN: begin
				cmd.op      = OP_HK;
				cmd.mul_sel = MS_HK;
				cmd.to_y    = last_stage;
				cmd.half    = last_stage ? is_heun : (is_rk4 && !stage_q[1]);
				if (last_stage) begin
					stage_d = 2'd0;
					if (last_step) begin
						state_d = S_PUB;
					end else begin
						step_d  = step_q + N_W'(1);
						state_d = S_Y2_MUL;
					end
				end else begin
					stage_d = stage_q + 2'd1;
					state_d = S_Y2_MUL;
				end
			end
			S_PUB: begin
				if (!ovalid_q || out_ready) begin
					cmd.op  = OP_PUB;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			stage_q  <= 2'd0;
			step_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			stage_q <= stage_d;
			step_q  <= step_d;
			if (cmd.op == OP_PUB) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign out_valid = ovalid_q;

endmodule

// ===== tb/tb_ode_fixed_step_integrator.sv =====
`timescale 1ns / 1ps

module tb_ode_fixed_step_integrator;
	import ofsi_pkg::*;

	localparam longint VMAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint VMIN = -VMAX - 1;
	localparam longint ONE  = 64'sd1 << FRAC_BITS;
	localparam logic [1:0] METH_RK4 = 2'd2;
	localparam logic [1:0] METH_ALT = 2'd3;

	typedef struct {
		logic [1:0]           action;
		logic signed [47:0]   x_end;
		logic signed [47:0]   x_start;
		logic signed [47:0]   y_start;
		logic [N_W-1:0]       step_count;
		bit                   known;
		logic signed [47:0]   y_exp;
		bit                   sat_exp;
	} request_t;

	typedef struct {
		logic signed [47:0] y;
		bit                 sat;
	} outcome_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] action;
	logic signed [VAL_W-1:0] x_end;
	logic signed [VAL_W-1:0] x_start;
	logic signed [VAL_W-1:0] y_start;
	logic [N_W-1:0] step_count;
	logic out_valid;
	logic out_ready;
	logic signed [VAL_W-1:0] y_end;
	logic saturated;
	logic cfg_wr_en;
	logic [MUL_W-1:0] cfg_wr_data;

	logic [63:0] coeff_model;
	bit          sat_model;
	outcome_t    pending_q[$];
	request_t    directed[$];
	int          errors;
	int          results_seen;
	bit          quiet;

	ode_fixed_step_integrator i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.x_end      (x_end),
		.x_start    (x_start),
		.y_start    (y_start),
		.step_count (step_count),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.y_end      (y_end),
		.saturated  (saturated),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [63:0] magnitude(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint clamp_val(longint v);
		if (v > VMAX) begin
			sat_model = 1'b1;
			return VMAX;
		end
		if (v < VMIN) begin
			sat_model = 1'b1;
			return VMIN;
		end
		return v;
	endfunction

	function automatic longint scaled_product(longint a, longint b, int sh);
		bit neg;
		logic [63:0] lim;
		logic [127:0] p;
		logic [127:0] s;
		neg = (a < 0) != (b < 0);
		lim = neg ? 64'h8000_0000_0000 : 64'(VMAX);
		p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
		s = p >> sh;
		if (s > {64'd0, lim}) begin
			sat_model = 1'b1;
			s = {64'd0, lim};
		end
		return neg ? -longint'(s[63:0]) : longint'(s[63:0]);
	endfunction

	// Slope is -(k * y^4) with y^2 clamped to 64 bits and k scaled by 2^-64.
	function automatic longint decay_slope(longint y);
		logic [127:0] p;
		logic [127:0] q;
		logic [127:0] t;
		logic [127:0] u;
		logic [63:0] a;
		logic [63:0] y2;
		logic [63:0] y4hi;
		logic [63:0] y4lo;
		logic [63:0] m;
		a = magnitude(y);
		p = {64'd0, a} * {64'd0, a};
		y2 = p[87:24];
		if (p[127:88] != 0) begin
			sat_model = 1'b1;
			y2 = '1;
		end
		q = {64'd0, y2} * {64'd0, y2};
		y4hi = {24'd0, q[127:88]};
		y4lo = q[87:24];
		t = {64'd0, coeff_model} * {64'd0, y4hi};
		u = {64'd0, coeff_model} * {64'd0, y4lo};
		m = t[63:0] + u[127:64];
		if (t[127:64] != 0 || m < t[63:0] || m > 64'(VMAX)) begin
			sat_model = 1'b1;
			m = 64'(VMAX);
		end
		return -longint'(m);
	endfunction

	function automatic outcome_t integrate(request_t r);
		outcome_t o;
		longint y;
		longint h;
		longint k1;
		longint k2;
		longint k3;
		longint k4;
		logic [63:0] n;
		logic [63:0] h_raw;
		sat_model = 1'b0;
		y = longint'(r.y_start);
		n = r.step_count;
		if (n == 0)
			n = 1;
		if (n > MAX_STEPS)
			n = MAX_STEPS;
		h_raw = magnitude(longint'(r.x_end) - longint'(r.x_start)) / n;
		if (h_raw > 64'(VMAX)) begin
			sat_model = 1'b1;
			h_raw = 64'(VMAX);
		end
		h = longint'(h_raw);
		for (longint i = 0; i < longint'(n); i++) begin
			k1 = decay_slope(y);
			if (r.action == METH_EULER) begin
				y = clamp_val(y + scaled_product(h, k1, FRAC_BITS));
			end else if (r.action == METH_HEUN) begin
				k2 = decay_slope(clamp_val(y + scaled_product(h, k1, FRAC_BITS)));
				y = clamp_val(y + scaled_product(h, k1 + k2, FRAC_BITS + 1));
			end else begin
				k2 = decay_slope(clamp_val(y + scaled_product(h, k1, FRAC_BITS + 1)));
				k3 = decay_slope(clamp_val(y + scaled_product(h, k2, FRAC_BITS + 1)));
				k4 = decay_slope(clamp_val(y + scaled_product(h, k3, FRAC_BITS)));
				y = clamp_val(y + scaled_product(h, (k1 + 2 * k2 + 2 * k3 + k4) / 6,
					FRAC_BITS));
			end
		end
		o.y = y[47:0];
		o.sat = sat_model;
		return o;
	endfunction

	task automatic report_mismatch(string what, longint want, longint got);
		$display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
		errors++;
	endtask

	function automatic request_t make_row(logic [1:0] a, longint xe, longint xs, longint ys,
			int n, bit known = 0, longint ye = 0, bit se = 0);
		request_t r;
		r.action = a;
		r.x_end = xe[47:0];
		r.x_start = xs[47:0];
		r.y_start = ys[47:0];
		r.step_count = n[N_W-1:0];
		r.known = known;
		r.y_exp = ye[47:0];
		r.sat_exp = se;
		return r;
	endfunction

	function automatic longint small_value(int units);
		return $signed(longint'($urandom_range(0, 2 * units * 256))) * (ONE / 256)
			- longint'(units) * ONE;
	endfunction

	function automatic request_t random_request();
		request_t r;
		longint xs;
		longint xe;
		longint ys;
		r.action = 2'($urandom_range(0, 3));
		xs = ($urandom_range(0, 1) == 0) ? longint'({$urandom, $urandom}) : small_value(8);
		xe = ($urandom_range(0, 2) == 0) ? longint'({$urandom, $urandom}) : xs + small_value(4);
		ys = ($urandom_range(0, 3) == 0) ? longint'({$urandom, $urandom}) : small_value(4);
		r.x_start = xs[47:0];
		r.x_end = xe[47:0];
		r.y_start = ys[47:0];
		r.step_count = ($urandom_range(0, 9) == 0) ? N_W'($urandom_range(17, 64))
			: N_W'($urandom_range(0, 16));
		r.known = 0;
		return r;
	endfunction

	task automatic send_request(request_t r);
		if (!quiet && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= r.action;
		x_end <= r.x_end;
		x_start <= r.x_start;
		y_start <= r.y_start;
		step_count <= r.step_count;
		do
			@(posedge clk);
		while (!in_ready);
		if (r.known)
			pending_q.push_back('{y: r.y_exp, sat: r.sat_exp});
		else
			pending_q.push_back(integrate(r));
	endtask

	task automatic drain_results();
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_coeff(logic [63:0] v);
		in_valid <= 1'b0;
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		coeff_model = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Each accepted result beat is matched against the oldest prediction.
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_q.size() == 0) begin
				$display("unexpected result beat at %0t", $realtime);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (y_end !== e.y)
					report_mismatch("y_end", longint'(e.y), longint'(y_end));
				if (saturated !== e.sat)
					report_mismatch("saturated", e.sat, saturated);
			end
		end
	end

	initial begin
		bit held;
		held = 0;
		out_ready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			@(posedge clk);
			if (!held && results_seen >= 20) begin
				// Long hold-off so the block fills and back-pressures its input.
				out_ready <= 1'b0;
				repeat (20000) @(posedge clk);
				held = 1;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16) - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#20ms;
		$display("timeout at %0t", $realtime);
		$display("** ode_fixed_step_integrator: FAILED **");
		$finish;
	end

	initial begin
		logic [63:0] coeffs[3];
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = METH_EULER;
		x_end = '0;
		x_start = '0;
		y_start = '0;
		step_count = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		errors = 0;
		results_seen = 0;
		quiet = 0;
		coeff_model = COEFF_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero start value has zero slope; zero width keeps y; too wide a step saturates h.
		directed.push_back(make_row(METH_EULER, ONE, 0, 0, 1, 1, 0, 0));
		directed.push_back(make_row(METH_HEUN, ONE, ONE, ONE, 5, 1, ONE, 0));
		directed.push_back(make_row(METH_RK4, VMAX, VMIN, 0, 1, 1, 0, 1));
		directed.push_back(make_row(METH_ALT, 4 * ONE, 0, ONE, 4));
		directed.push_back(make_row(METH_EULER, 2 * ONE, 0, ONE, 0));
		directed.push_back(make_row(METH_EULER, 8 * ONE, 0, 2 * ONE, 2047));
		directed.push_back(make_row(METH_RK4, 8 * ONE, 0, 2 * ONE, 1024));
		directed.push_back(make_row(METH_HEUN, -3 * ONE, 5 * ONE, ONE, 7));
		directed.push_back(make_row(METH_EULER, ONE, 0, VMAX, 3));
		directed.push_back(make_row(METH_HEUN, ONE, 0, VMIN, 3));
		directed.push_back(make_row(METH_RK4, ONE, 0, VMAX, 2));
		directed.push_back(make_row(METH_RK4, ONE, 0, VMIN, 2));
		directed.push_back(make_row(METH_EULER, VMAX, 0, ONE, 1));
		directed.push_back(make_row(METH_HEUN, 0, VMIN, -ONE, 1));
		directed.push_back(make_row(METH_RK4, -1, 0, 1, 1));

		foreach (directed[i])
			send_request(directed[i]);
		repeat (25) send_request(random_request());

		coeffs[0] = '0;
		coeffs[1] = '1;
		coeffs[2] = {$urandom, $urandom};
		foreach (coeffs[p]) begin
			write_coeff(coeffs[p]);
			if (p == 2)
				quiet = 1;
			if (p == 1) begin
				send_request(make_row(METH_EULER, ONE, 0, ONE, 1));
				send_request(make_row(METH_RK4, 4 * ONE, 0, VMAX, 3));
			end
			repeat (25) send_request(random_request());
		end

		in_valid <= 1'b0;
		drain_results();
		if (errors == 0)
			$display("** ode_fixed_step_integrator: PASSED **");
		else
			$display("** ode_fixed_step_integrator: FAILED **");
		$finish;
	end

endmodule

// ===== ode_fixed_step_integrator.f =====
rtl/ofsi_pkg.sv
rtl/ofsi_mul.sv
rtl/ofsi_div.sv
rtl/ofsi_dp.sv
rtl/ofsi_ctrl.sv
rtl/ode_fixed_step_integrator.sv
tb/tb_ode_fixed_step_integrator.sv
